@@ design/distance_bound_path_prune_defines.svh @@
// Assertion macros for the distance bound pruning block.
// No dependencies; compiled before the RTL files.
`ifndef DISTANCE_BOUND_PATH_PRUNE_DEFINES_SVH
`define DISTANCE_BOUND_PATH_PRUNE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DBP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define DBP_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DBP_ASSERT(label, clk, rst_n, prop)
`define DBP_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ design/dbp_pkg.sv @@
// Shared types and constants for the distance bound pruning block.
// No dependencies.
`default_nettype none
package dbp_pkg;
  localparam int DefMaxAtoms = 256;
  localparam int CoordW = 24;
  localparam int CntW = 9;
  localparam logic [1:0] OP_POS = 2'd0;
  localparam logic [1:0] OP_BOUND = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [0:0] REG_NUM_ATOMS = 1'd0;
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LDJ  = 6'b000010,
    S_LDI  = 6'b000100,
    S_DIST = 6'b001000,
    S_WALK = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;
endpackage
`default_nettype wire

@@ design/distance_bound_path_prune.sv @@
// Top level of the distance bound pruning block: loader, memories, query walker.
// Depends on dbp_pkg and distance_bound_path_prune_defines.svh.
`default_nettype none
`include "distance_bound_path_prune_defines.svh"
module distance_bound_path_prune #(
  parameter int MAX_ATOMS = dbp_pkg::DefMaxAtoms
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata from bit 0: opcode[1:0], atom_index[9:2], partner_index[17:10],
  // coord_x[41:18], coord_y[65:42], coord_z[89:66], is_duplicate[90],
  // bound_defined[91], bound_upper[115:92], zero fill to 120
  input  wire logic [119:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata from bit 0: prune[0], zero fill to 8
  output logic [7:0]       out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  // Every word yields one result, and the input stays closed until that result
  // is taken. A write, an ignored opcode and a query at level 0 or at n-1 and
  // beyond show their result the cycle after acceptance. A full query at level
  // j with n atoms in use visits each non-duplicate earlier atom i and stops
  // early on a hit: it reads i and forms the squares, then walks the later
  // atoms k at one per cycle, set by one position read and two bound reads
  // per cycle.
  // Memories come up unwritten; no clearing pass.
  import dbp_pkg::*;
  localparam int AW = $clog2(MAX_ATOMS);
  localparam int PW = 2 * AW;

  logic [1:0] op;
  logic [7:0] a_in, b_in;
  assign op = in_tdata[1:0];
  assign a_in = in_tdata[9:2];
  assign b_in = in_tdata[17:10];

  logic [CntW-1:0] num_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(32-CntW){1'b0}}, num_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= 9'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr == 2'({REG_NUM_ATOMS, 2'b00})) begin
      num_r <= cfg_pwdata[CntW-1:0];
    end
  end
  logic [12:0] n_eff;
  assign n_eff = ({4'd0, num_r} < 13'(MAX_ATOMS)) ? {4'd0, num_r} : 13'(MAX_ATOMS);

  // position memory: x,y,z,dup; bound memory: two read ports
  logic [3*CoordW:0] pos_mem [MAX_ATOMS];
  logic [CoordW:0]   bnd_mem [2**PW];
  logic [3*CoordW:0] pos_rd;
  logic [CoordW:0]   bik_rd, bjk_rd;
  logic [AW-1:0] pos_ra;
  logic [PW-1:0] bra0, bra1;

  state_t st_r;
  logic [AW-1:0] j_r, i_r, k_r;
  logic signed [CoordW-1:0] jx_r, jy_r, jz_r;
  logic [49:0] d2_r;
  logic [47:0] sq_x_r, sq_y_r, sq_z_r;
  logic prune_r, kv_r;
  logic [AW-1:0] kq_r;

  wire acc = in_tvalid && in_tready;
  wire in_rng_a = 32'(a_in) < MAX_ATOMS;
  wire in_rng_b = 32'(b_in) < MAX_ATOMS;
  assign in_tready = (st_r == S_IDLE) && !out_tvalid;

  function automatic logic [PW-1:0] slot(logic [AW-1:0] x, logic [AW-1:0] y);
    logic [AW-1:0] lo, hi;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    return {lo, hi};
  endfunction

  always_ff @(posedge clk) begin
    if (acc && op == OP_POS && in_rng_a)
      pos_mem[AW'(a_in)] <= {in_tdata[90], in_tdata[89:18]};
    if (acc && op == OP_BOUND && in_rng_a && in_rng_b)
      bnd_mem[slot(AW'(a_in), AW'(b_in))] <= {in_tdata[91], in_tdata[115:92]};
    pos_rd <= pos_mem[pos_ra];
    bik_rd <= bnd_mem[bra0];
    bjk_rd <= bnd_mem[bra1];
  end

  // k walk issue: pos and bounds of k read together each cycle
  always_comb begin
    pos_ra = k_r;
    if (st_r == S_IDLE) pos_ra = AW'(a_in);
    else if (st_r == S_LDJ || st_r == S_LDI) pos_ra = i_r;
    bra0 = slot(i_r, k_r);
    bra1 = slot(j_r, k_r);
  end

  wire signed [CoordW:0] dx = $signed(pos_rd[CoordW-1:0]) - jx_r;
  wire signed [CoordW:0] dy = $signed(pos_rd[2*CoordW-1:CoordW]) - jy_r;
  wire signed [CoordW:0] dz = $signed(pos_rd[3*CoordW-1:2*CoordW]) - jz_r;
  wire [CoordW:0] s_b = {1'b0, bik_rd[CoordW-1:0]} + {1'b0, bjk_rd[CoordW-1:0]};
  wire [49:0] s2 = 50'(s_b * s_b);
  wire kdup = pos_rd[3*CoordW];
  wire hit = kv_r && !kdup && bik_rd[CoordW] && bjk_rd[CoordW] && (d2_r > s2);
  wire [12:0] k_nx = 13'(k_r) + 13'd1;
  wire k_last = (k_nx >= n_eff);

  logic idist_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_tvalid <= 1'b0;
      prune_r <= 1'b0;
      kv_r <= 1'b0;
      idist_r <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (acc) begin
          prune_r <= 1'b0;
          j_r <= AW'(a_in);
          i_r <= AW'(a_in) - AW'(1);
          if (op == OP_QUERY && a_in != 8'd0 && 13'(a_in) < n_eff
              && 13'(a_in) + 13'd1 < n_eff) st_r <= S_LDJ;
          else out_tvalid <= 1'b1;
        end
        S_LDJ: begin
          jx_r <= $signed(pos_rd[CoordW-1:0]);
          jy_r <= $signed(pos_rd[2*CoordW-1:CoordW]);
          jz_r <= $signed(pos_rd[3*CoordW-1:2*CoordW]);
          st_r <= S_LDI;
        end
        S_LDI: st_r <= S_DIST;
        S_DIST: begin
          // hold i's squares; skip duplicates
          sq_x_r <= 48'(dx * dx);
          sq_y_r <= 48'(dy * dy);
          sq_z_r <= 48'(dz * dz);
          if (pos_rd[3*CoordW]) begin
            idist_r <= 1'b0;
            if (i_r == '0) begin
              st_r <= S_OUT;
            end else begin
              i_r <= i_r - AW'(1);
              st_r <= S_LDI;
            end
          end else begin
            idist_r <= 1'b1;
            k_r <= j_r + AW'(1);
            kv_r <= 1'b0;
            st_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (idist_r) begin
            d2_r <= 50'(sq_x_r) + 50'(sq_y_r) + 50'(sq_z_r);
            idist_r <= 1'b0;
          end
          kq_r <= k_r;
          if (hit) begin
            prune_r <= 1'b1;
            kv_r <= 1'b0;
            st_r <= S_OUT;
          end else if (kv_r && 13'(kq_r) + 13'd1 >= n_eff) begin
            kv_r <= 1'b0;
            if (i_r == '0) st_r <= S_OUT;
            else begin
              i_r <= i_r - AW'(1);
              st_r <= S_LDI;
            end
          end else begin
            kv_r <= 1'b1;
            if (!k_last) k_r <= AW'(k_nx);
          end
        end
        S_OUT: begin
          out_tvalid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {7'd0, prune_r};

  `DBP_ASSERT(a_no_accept_busy, clk, rst_n, (st_r != S_IDLE) |-> !in_tready)
  `DBP_ASSERT(a_result_once, clk, rst_n, (out_tvalid && out_tready) |=> !out_tvalid)
  `DBP_ASSERT(a_out_only_idle, clk, rst_n, out_tvalid |-> (st_r == S_IDLE))
endmodule
`default_nettype wire
